// ===== hw/rtl/mpmc_pkg.sv =====
package mpmc_pkg;

   localparam int SYMBOL_BITS = 8;
   localparam int SYMBOLS     = 256;
   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_LF = 8'd10;

   localparam logic [2:0] KIND_INSERT = 3'd0;
   localparam logic [2:0] KIND_BUILD  = 3'd1;
   localparam logic [2:0] KIND_RESET  = 3'd2;
   localparam logic [2:0] KIND_MATCH  = 3'd3;
   localparam logic [2:0] KIND_READ   = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NODE_FULL = 2'd1;
   localparam logic [1:0] ST_KEY_FULL  = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CLEAR,
      S_INS_RD,
      S_INS_WAIT,
      S_INS_DEC,
      S_BLD_ROOT_RD,
      S_BLD_ROOT_WAIT,
      S_BLD_POP,
      S_BLD_POP_WAIT,
      S_BLD_SYM_RD,
      S_BLD_SYM_WAIT,
      S_BLD_F_RD,
      S_BLD_F_WAIT,
      S_BLD_FL_RD,
      S_BLD_FL_WAIT,
      S_M_RD,
      S_M_WAIT,
      S_M_FL_RD,
      S_M_FL_WAIT,
      S_OUT_RD,
      S_OUT_WAIT,
      S_OUT_CNT,
      S_OUT_CNT_WAIT,
      S_RD_WAIT,
      S_DONE
   } state_type;

endpackage

// ===== hw/rtl/mpmc_goto_mem.sv =====
module mpmc_goto_mem
   import mpmc_pkg::*;
#(
   parameter int ADDR_BITS = 16,
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/multi_pattern_match_counter.sv =====
// multi_pattern_match_counter: keyword trie with failure links and per-keyword
// hit counters.
// req channel (valid/stall): kind selects insert byte, build links, reset
// match, match byte or read counter. one rsp word per req word.
// the block takes one req word at a time; req_stall is high while a word is
// in work or its rsp word waits.
// reset match and cr/lf match bytes go straight to the rsp word; a match
// byte walks failure links, then the output chain, with a counter update
// for each end node on it; build scans the root's 256 symbols, then those
// of each queued node with a failure walk per child. an insert word
// allocates a node when its goto entry is empty. the goto memory has a
// single registered read port, so each step waits for its read data.
// after reset a clearing pass zeroes every goto memory entry; req_stall
// stays high through it. counters are cleared by a 64-entry valid mask
// that reset and the reset-match kind clear at once.
// a stalled rsp word holds until rsp_stall drops.
module multi_pattern_match_counter
   import mpmc_pkg::*;
#(
   parameter int NODE_COUNT     = 256,
   parameter int KEYWORD_COUNT  = 64,
   parameter int COUNTER_BITS   = 32,
   parameter int MAX_KEY_LENGTH = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_symbol,
   input  logic        req_word_end,
   input  logic [5:0]  req_key_select,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_count_value,
   output logic [6:0]  rsp_hits_now,
   output logic [1:0]  rsp_status
);

   localparam int NB = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
   localparam int KB = (KEYWORD_COUNT > 1) ? $clog2(KEYWORD_COUNT) : 1;
   localparam int GB = NB + SYMBOL_BITS;
   localparam int UB = $clog2(NODE_COUNT + 1);
   localparam int WB = $clog2(KEYWORD_COUNT + 1);
   localparam int HB = $clog2(NODE_COUNT + 1);
   localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
   localparam logic [UB-1:0] NODE_LIM = UB'(NODE_COUNT);
   localparam logic [WB-1:0] KEY_LIM = WB'(KEYWORD_COUNT);
   localparam logic [8:0] LEN_LIM = 9'(MAX_KEY_LENGTH);

   state_type state_ff, state_in;

   // goto memory port
   logic          g_we;
   logic [GB-1:0] g_wa, g_ra;
   logic [NB-1:0] g_wd, g_rd;

   mpmc_goto_mem #(.ADDR_BITS(GB), .DATA_BITS(NB)) u_goto (
      .clock  (clock),
      .wr_en  (g_we),
      .wr_addr(g_wa),
      .wr_data(g_wd),
      .rd_addr(g_ra),
      .rd_data(g_rd)
   );

   // node memories
   logic [NB-1:0] fail_mem [NODE_COUNT];
   logic          end_mem  [NODE_COUNT];
   logic [KB-1:0] kid_mem  [NODE_COUNT];
   logic [7:0]    dep_mem  [NODE_COUNT];
   logic [NB-1:0] queue_mem [NODE_COUNT];
   logic [COUNTER_BITS-1:0] cnt_mem [KEYWORD_COUNT];
   logic [KEYWORD_COUNT-1:0] cnt_ok_ff, cnt_ok_in;

   logic          n_we;
   logic [NB-1:0] n_wa, n_ra;
   logic          n_we_fail, n_we_end, n_we_kid, n_we_dep;
   logic [NB-1:0] n_wfail;
   logic          n_wend;
   logic [KB-1:0] n_wkid;
   logic [7:0]    n_wdep;
   logic [NB-1:0] n_rfail_ff;
   logic          n_rend_ff;
   logic [KB-1:0] n_rkid_ff;
   logic [7:0]    n_rdep_ff;

   always_ff @(posedge clock) begin
      if (n_we && n_we_fail) fail_mem[n_wa] <= n_wfail;
      if (n_we && n_we_end)  end_mem[n_wa]  <= n_wend;
      if (n_we && n_we_kid)  kid_mem[n_wa]  <= n_wkid;
      if (n_we && n_we_dep)  dep_mem[n_wa]  <= n_wdep;
      n_rfail_ff <= fail_mem[n_ra];
      n_rend_ff  <= end_mem[n_ra];
      n_rkid_ff  <= kid_mem[n_ra];
      n_rdep_ff  <= dep_mem[n_ra];
   end

   logic          q_we;
   logic [NB-1:0] q_wa, q_wd, q_ra, q_rd_ff;
   always_ff @(posedge clock) begin
      if (q_we) queue_mem[q_wa] <= q_wd;
      q_rd_ff <= queue_mem[q_ra];
   end

   logic                    c_we;
   logic [KB-1:0]           c_wa, c_ra;
   logic [COUNTER_BITS-1:0] c_wd, c_rd_ff;
   always_ff @(posedge clock) begin
      if (c_we) cnt_mem[c_wa] <= c_wd;
      c_rd_ff <= cnt_mem[c_ra];
   end

   // control registers
   logic [UB-1:0] used_ff, used_in;
   logic [WB-1:0] kwu_ff, kwu_in;
   logic [NB-1:0] cursor_ff, cursor_in;
   logic [NB-1:0] cur_ff, cur_in;
   logic [1:0]    hold_ff, hold_in;
   logic          dep_ok_ff, dep_ok_in;
   logic [GB:0]   clr_ff, clr_in;
   logic [2:0]    kind_ff, kind_in;
   logic [7:0]    sym_ff, sym_in;
   logic          last_ff, last_in;
   logic [5:0]    sel_ff, sel_in;
   logic [NB-1:0] s_ff, s_in;       // walk node
   logic [NB-1:0] p_ff, p_in;       // build parent
   logic [NB-1:0] ch_ff, ch_in;     // build child
   logic [NB-1:0] f_ff, f_in;       // build failure walk
   logic [8:0]    c_ff, c_in;       // build symbol
   logic [UB-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [HB-1:0] step_ff, step_in;
   logic [6:0]    hits_ff, hits_in;
   logic [1:0]    st_ff, st_in;
   logic [7:0]    cdep_ff, cdep_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_cnt_ff, rsp_cnt_in;
   logic [6:0]    rsp_hits_ff, rsp_hits_in;
   logic [1:0]    rsp_st_ff, rsp_st_in;

   logic req_acc;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign req_acc = req_valid && !req_stall;

   logic [COUNTER_BITS-1:0] cval;
   logic [KB-1:0]           kid_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ok_ff    <= '0;
         used_ff      <= UB'(1);
         kwu_ff       <= '0;
         cursor_ff    <= '0;
         cur_ff       <= '0;
         hold_ff      <= ST_OK;
         dep_ok_ff    <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ok_ff    <= cnt_ok_in;
         used_ff      <= used_in;
         kwu_ff       <= kwu_in;
         cursor_ff    <= cursor_in;
         cur_ff       <= cur_in;
         hold_ff      <= hold_in;
         dep_ok_ff    <= dep_ok_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      sym_ff      <= sym_in;
      last_ff     <= last_in;
      sel_ff      <= sel_in;
      s_ff        <= s_in;
      p_ff        <= p_in;
      ch_ff       <= ch_in;
      f_ff        <= f_in;
      c_ff        <= c_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      step_ff     <= step_in;
      hits_ff     <= hits_in;
      st_ff       <= st_in;
      cdep_ff     <= cdep_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_hits_ff <= rsp_hits_in;
      rsp_st_ff   <= rsp_st_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_ok_in    = cnt_ok_ff;
      used_in      = used_ff;
      kwu_in       = kwu_ff;
      cursor_in    = cursor_ff;
      cur_in       = cur_ff;
      hold_in      = hold_ff;
      dep_ok_in    = dep_ok_ff;
      clr_in       = clr_ff;
      kind_in      = kind_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      sel_in       = sel_ff;
      s_in         = s_ff;
      p_in         = p_ff;
      ch_in        = ch_ff;
      f_in         = f_ff;
      c_in         = c_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      step_in      = step_ff;
      hits_in      = hits_ff;
      st_in        = st_ff;
      cdep_in      = cdep_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_hits_in  = rsp_hits_ff;
      rsp_st_in    = rsp_st_ff;
      g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
      n_we = 1'b0; n_wa = '0; n_ra = '0;
      n_we_fail = 1'b0; n_we_end = 1'b0; n_we_kid = 1'b0; n_we_dep = 1'b0;
      n_wfail = '0; n_wend = 1'b0; n_wkid = '0; n_wdep = '0;
      q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
      c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
      cval = '0;
      kid_now = n_rkid_ff;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            g_we = 1'b1;
            g_wa = clr_ff[GB-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff[GB-1:0] == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) begin
               kind_in = req_kind;
               sym_in  = req_symbol;
               last_in = req_word_end;
               sel_in  = req_key_select;
               hits_in = '0;
               st_in   = ST_OK;
               case (req_kind)
                  KIND_INSERT: state_in = S_INS_RD;
                  KIND_BUILD: begin
                     c_in = '0;
                     tail_in = '0;
                     head_in = '0;
                     state_in = S_BLD_ROOT_RD;
                  end
                  KIND_RESET: begin
                     cur_in = '0;
                     cnt_ok_in = '0;
                     state_in = S_DONE;
                  end
                  KIND_MATCH: begin
                     if (req_symbol == CH_CR || req_symbol == CH_LF) begin
                        state_in = S_DONE;
                     end else begin
                        s_in = cur_ff;
                        step_in = '0;
                        state_in = S_M_RD;
                     end
                  end
                  KIND_READ: begin
                     state_in = S_RD_WAIT;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         // ---- insert ----
         S_INS_RD: begin
            g_ra = {cursor_ff, sym_ff};
            n_ra = cursor_ff;
            state_in = S_INS_WAIT;
         end
         S_INS_WAIT: begin
            g_ra = {cursor_ff, sym_ff};
            n_ra = cursor_ff;
            state_in = S_INS_DEC;
         end
         S_INS_DEC: begin
            g_ra = {cursor_ff, sym_ff};
            state_in = S_DONE;
            if (hold_ff != ST_OK) begin
               st_in = hold_ff;
               if (last_ff) begin
                  hold_in = ST_OK;
                  cursor_in = '0;
               end
            end else begin
               // depth reads as zero at the root and until the first node is written
               cdep_in = (cursor_ff == '0 || !dep_ok_ff) ? 8'd0 : n_rdep_ff;
               if (({1'b0, cdep_in} + 9'd1) > LEN_LIM) begin
                  st_in = ST_NODE_FULL;
               end else if (g_rd == '0 && used_ff >= NODE_LIM) begin
                  st_in = ST_NODE_FULL;
               end else begin
                  state_in = S_OUT_RD;  // reused as end check below
                  if (g_rd == '0) begin
                     ch_in = used_ff[NB-1:0];
                     used_in = used_ff + 1'b1;
                     g_we = 1'b1;
                     g_wa = {cursor_ff, sym_ff};
                     g_wd = used_ff[NB-1:0];
                     n_we = 1'b1;
                     n_wa = used_ff[NB-1:0];
                     n_we_fail = 1'b1; n_we_end = 1'b1;
                     n_we_kid = 1'b1; n_we_dep = 1'b1;
                     n_wdep = cdep_in + 8'd1;
                     dep_ok_in = 1'b1;
                  end else begin
                     ch_in = g_rd;
                  end
                  kind_in = KIND_INSERT;
               end
               if (st_in != ST_OK) begin
                  cursor_in = '0;
                  if (!last_ff) hold_in = st_in;
               end
            end
         end

         // ---- build ----
         S_BLD_ROOT_RD: begin
            g_ra = {{NB{1'b0}}, c_ff[7:0]};
            state_in = S_BLD_ROOT_WAIT;
         end
         S_BLD_ROOT_WAIT: begin
            if (g_rd != '0) begin
               n_we = 1'b1; n_wa = g_rd; n_we_fail = 1'b1; n_wfail = '0;
               if (tail_ff < NODE_LIM) begin
                  q_we = 1'b1; q_wa = tail_ff[NB-1:0]; q_wd = g_rd;
                  tail_in = tail_ff + 1'b1;
               end
            end
            c_in = c_ff + 1'b1;
            state_in = (c_ff == 9'd255) ? S_BLD_POP : S_BLD_ROOT_RD;
         end
         S_BLD_POP: begin
            if (head_ff >= tail_ff) begin
               state_in = S_DONE;
            end else begin
               q_ra = head_ff[NB-1:0];
               head_in = head_ff + 1'b1;
               state_in = S_BLD_POP_WAIT;
            end
         end
         S_BLD_POP_WAIT: begin
            p_in = q_rd_ff;
            c_in = '0;
            state_in = S_BLD_SYM_RD;
         end
         S_BLD_SYM_RD: begin
            g_ra = {p_ff, c_ff[7:0]};
            n_ra = p_ff;
            state_in = S_BLD_SYM_WAIT;
         end
         S_BLD_SYM_WAIT: begin
            if (g_rd == '0) begin
               c_in = c_ff + 1'b1;
               state_in = (c_ff == 9'd255) ? S_BLD_POP : S_BLD_SYM_RD;
            end else begin
               ch_in = g_rd;
               if (tail_ff < NODE_LIM) begin
                  q_we = 1'b1; q_wa = tail_ff[NB-1:0]; q_wd = g_rd;
                  tail_in = tail_ff + 1'b1;
               end
               f_in = n_rfail_ff;
               step_in = '0;
               state_in = S_BLD_F_RD;
            end
         end
         S_BLD_F_RD: begin
            g_ra = {f_ff, c_ff[7:0]};
            n_ra = f_ff;
            state_in = S_BLD_F_WAIT;
         end
         S_BLD_F_WAIT: begin
            if (g_rd != '0 || f_ff == '0 || step_ff == HB'(NODE_COUNT)) begin
               n_we = 1'b1; n_wa = ch_ff; n_we_fail = 1'b1; n_wfail = g_rd;
               c_in = c_ff + 1'b1;
               state_in = (c_ff == 9'd255) ? S_BLD_POP : S_BLD_SYM_RD;
            end else begin
               f_in = n_rfail_ff;
               step_in = step_ff + 1'b1;
               state_in = S_BLD_F_RD;
            end
         end

         // ---- match ----
         S_M_RD: begin
            g_ra = {s_ff, sym_ff};
            n_ra = s_ff;
            state_in = S_M_WAIT;
         end
         S_M_WAIT: begin
            if (g_rd != '0) begin
               s_in = g_rd;
               cur_in = g_rd;
               state_in = S_OUT_RD;
            end else if (s_ff == '0 || step_ff == HB'(NODE_COUNT)) begin
               cur_in = s_ff;
               state_in = S_OUT_RD;
            end else begin
               s_in = n_rfail_ff;
               step_in = step_ff + 1'b1;
               state_in = S_M_RD;
            end
            ch_in = s_in;
            step_in = (state_in == S_OUT_RD) ? '0 : step_in;
         end

         // ---- output chain (match) / end marking (insert) ----
         S_OUT_RD: begin
            n_ra = ch_ff;
            state_in = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            n_ra = ch_ff;
            if (kind_ff == KIND_INSERT) begin
               state_in = S_DONE;
               if (last_ff && !n_rend_ff) begin
                  if (kwu_ff >= KEY_LIM) begin
                     st_in = ST_KEY_FULL;
                     cursor_in = '0;
                  end else begin
                     n_we = 1'b1; n_wa = ch_ff;
                     n_we_end = 1'b1; n_wend = 1'b1;
                     n_we_kid = 1'b1; n_wkid = kwu_ff[KB-1:0];
                     kwu_in = kwu_ff + 1'b1;
                  end
               end
               if (st_in == ST_OK) cursor_in = last_ff ? '0 : ch_ff;
            end else if (ch_ff == '0 || step_ff == HB'(NODE_COUNT)) begin
               state_in = S_DONE;
            end else if (n_rend_ff) begin
               c_ra = kid_now;
               f_in = n_rfail_ff;
               state_in = S_OUT_CNT_WAIT;
            end else begin
               ch_in = n_rfail_ff;
               step_in = step_ff + 1'b1;
               state_in = S_OUT_RD;
            end
         end
         S_OUT_CNT_WAIT: begin
            n_ra = ch_ff;
            c_ra = kid_now;
            state_in = S_OUT_CNT;
         end
         S_OUT_CNT: begin
            cval = cnt_ok_ff[n_rkid_ff] ? c_rd_ff : '0;
            c_we = 1'b1;
            c_wa = n_rkid_ff;
            c_wd = (cval == CNT_MAX) ? cval : cval + 1'b1;
            cnt_ok_in[n_rkid_ff] = 1'b1;
            hits_in = hits_ff + 7'd1;
            ch_in = f_ff;
            step_in = step_ff + 1'b1;
            state_in = S_OUT_RD;
         end

         // ---- read ----
         S_RD_WAIT: begin
            c_ra = KB'(sel_ff);
            state_in = S_DONE;
            kind_in = KIND_READ;
            rsp_cnt_in = '0;
         end

         S_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_cnt_in = '0;
               rsp_hits_in = '0;
               rsp_st_in = ST_OK;
               case (kind_ff)
                  KIND_INSERT: rsp_st_in = st_ff;
                  KIND_MATCH:  rsp_hits_in = hits_ff;
                  KIND_READ: begin
                     if ({26'd0, sel_ff} < 32'(KEYWORD_COUNT) &&
                         cnt_ok_ff[KB'(sel_ff)]) begin
                        cval = c_rd_ff;
                        rsp_cnt_in = 32'(cval);
                     end
                  end
                  default: ;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_count_value = rsp_cnt_ff;
   assign rsp_hits_now    = rsp_hits_ff;
   assign rsp_status      = rsp_st_ff;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench
   import mpmc_pkg::*;
();

   localparam int NODES    = 256;
   localparam int KEYWORDS = 64;
   localparam int MAX_LEN  = 255;
   localparam int QUIET_LIMIT = 600000;

   typedef struct packed {
      logic [31:0] count_value;
      logic [6:0]  hits_now;
      logic [1:0]  status;
   } rsp_word_type;

   class keyword_scoreboard;
      logic [7:0]  child [NODES*SYMBOLS];
      logic [7:0]  fail_to [NODES];
      logic        is_end [NODES];
      logic [5:0]  key_id [NODES];
      logic [7:0]  depth [NODES];
      int          nodes_used;
      int          keys_used;
      logic [7:0]  cursor;
      logic [7:0]  state;
      logic [1:0]  drop_status;
      logic [31:0] counts [KEYWORDS];
      rsp_word_type expected [$];
      int          errors;

      function new();
         foreach (child[i]) child[i] = '0;
         foreach (fail_to[i]) begin
            fail_to[i] = '0;
            is_end[i] = 1'b0;
            key_id[i] = '0;
            depth[i] = '0;
         end
         foreach (counts[i]) counts[i] = '0;
         nodes_used = 1;
         keys_used = 0;
         cursor = '0;
         state = '0;
         drop_status = ST_OK;
         errors = 0;
      endfunction

      function logic [1:0] add_keyword_byte(logic [7:0] sym, logic last);
         logic [1:0] st;
         int nxt;
         st = ST_OK;
         if (drop_status != ST_OK) begin
            st = drop_status;
            if (last) begin
               drop_status = ST_OK;
               cursor = '0;
            end
            return st;
         end
         if (int'(depth[cursor]) + 1 > MAX_LEN) st = ST_NODE_FULL;
         else begin
            nxt = child[cursor*SYMBOLS + sym];
            if (nxt == 0) begin
               if (nodes_used >= NODES) st = ST_NODE_FULL;
               else begin
                  nxt = nodes_used++;
                  child[cursor*SYMBOLS + sym] = nxt[7:0];
                  fail_to[nxt] = '0;
                  is_end[nxt] = 1'b0;
                  key_id[nxt] = '0;
                  depth[nxt] = depth[cursor] + 8'd1;
               end
            end
            if (st == ST_OK) begin
               if (last && !is_end[nxt]) begin
                  if (keys_used >= KEYWORDS) st = ST_KEY_FULL;
                  else begin
                     is_end[nxt] = 1'b1;
                     key_id[nxt] = keys_used[5:0];
                     keys_used++;
                  end
               end
               cursor = last ? 8'd0 : nxt[7:0];
               return st;
            end
         end
         cursor = '0;
         if (!last) drop_status = st;
         return st;
      endfunction

      function void build_links();
         int bfs [$];
         int p, ch, f, g;
         fail_to[0] = '0;
         for (int c = 0; c < SYMBOLS; c++) begin
            ch = child[c];
            if (ch != 0) begin
               fail_to[ch] = '0;
               bfs.push_back(ch);
            end
         end
         while (bfs.size() > 0) begin
            p = bfs.pop_front();
            for (int c = 0; c < SYMBOLS; c++) begin
               ch = child[p*SYMBOLS + c];
               if (ch == 0) continue;
               bfs.push_back(ch);
               f = fail_to[p];
               fail_to[ch] = '0;
               for (int n = 0; n <= NODES; n++) begin
                  g = child[f*SYMBOLS + c];
                  if (g != 0) begin
                     fail_to[ch] = g[7:0];
                     break;
                  end
                  if (f == 0) break;
                  f = fail_to[f];
               end
            end
         end
      endfunction

      function logic [6:0] scan_byte(logic [7:0] sym);
         int s, t, ch, hits;
         hits = 0;
         if (sym == CH_CR || sym == CH_LF) return '0;
         s = state;
         for (int n = 0; n <= NODES; n++) begin
            ch = child[s*SYMBOLS + sym];
            if (ch != 0) begin
               s = ch;
               break;
            end
            if (s == 0) break;
            s = fail_to[s];
         end
         state = s[7:0];
         t = s;
         for (int n = 0; n < NODES && t != 0; n++) begin
            if (is_end[t]) begin
               if (counts[key_id[t]] != 32'hffff_ffff) counts[key_id[t]]++;
               hits++;
            end
            t = fail_to[t];
         end
         return hits[6:0];
      endfunction

      function void note(logic [2:0] kind, logic [7:0] sym, logic last, logic [5:0] sel);
         rsp_word_type w;
         w = '0;
         case (kind)
            KIND_INSERT: w.status = add_keyword_byte(sym, last);
            KIND_BUILD: build_links();
            KIND_RESET: begin
               state = '0;
               foreach (counts[i]) counts[i] = '0;
            end
            KIND_MATCH: w.hits_now = scan_byte(sym);
            KIND_READ: w.count_value = counts[sel];
            default: ;
         endcase
         expected.push_back(w);
      endfunction

      function void check(rsp_word_type got);
         rsp_word_type w;
         if (expected.size() == 0) begin
            $error("unexpected rsp word %h", got);
            errors++;
            return;
         end
         w = expected.pop_front();
         if (got.count_value !== w.count_value) begin
            $error("count_value exp %0d got %0d", w.count_value, got.count_value);
            errors++;
         end
         if (got.hits_now !== w.hits_now) begin
            $error("hits_now exp %0d got %0d", w.hits_now, got.hits_now);
            errors++;
         end
         if (got.status !== w.status) begin
            $error("status exp %0d got %0d", w.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_kind;
   logic [7:0]  req_symbol;
   logic        req_word_end;
   logic [5:0]  req_key_select;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_count_value;
   logic [6:0]  rsp_hits_now;
   logic [1:0]  rsp_status;

   keyword_scoreboard sb;
   int send_idle;
   int recv_idle;
   int quiet;

   multi_pattern_match_counter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_symbol(req_symbol),
      .req_word_end(req_word_end), .req_key_select(req_key_select),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_count_value(rsp_count_value), .rsp_hits_now(rsp_hits_now),
      .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_idle);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check({rsp_count_value, rsp_hits_now, rsp_status});
   end

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send(logic [2:0] kind, logic [7:0] sym, logic last, logic [5:0] sel);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_kind <= kind;
      req_symbol <= sym;
      req_word_end <= last;
      req_key_select <= sel;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note(kind, sym, last, sel);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_symbol();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hff;
         2: return 8'($urandom);
         default: return 8'h61 + 8'($urandom_range(3));
      endcase
   endfunction

   task automatic send_keyword(int len);
      for (int i = 0; i < len; i++)
         send(KIND_INSERT, pick_symbol(), i == len - 1, 6'($urandom));
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send(KIND_MATCH, s[i], 1'b0, 6'($urandom));
   endtask

   task automatic send_key(string s);
      for (int i = 0; i < s.len(); i++) send(KIND_INSERT, s[i], i == s.len() - 1, 6'd0);
   endtask

   task automatic run_phase(int items, int words, int long_len);
      int sent;
      int r;
      sent = 0;
      if (long_len > 0) begin
         send_keyword(long_len);
         sent += long_len;
      end
      for (int w = 0; w < words; w++) begin
         r = $urandom_range(1, 4);
         send_keyword(r);
         sent += r;
      end
      send(KIND_BUILD, 8'($urandom), 1'($urandom), 6'($urandom));
      while (sent < items) begin
         r = $urandom_range(99);
         if (r < 55) begin
            if ($urandom_range(19) == 0)
               send(KIND_MATCH, $urandom_range(1) ? CH_CR : CH_LF, 1'($urandom), 6'($urandom));
            else send(KIND_MATCH, pick_symbol(), 1'($urandom), 6'($urandom));
            sent++;
         end else if (r < 75) begin
            send(KIND_READ, 8'($urandom), 1'($urandom), 6'($urandom));
            sent++;
         end else if (r < 79) begin
            send(KIND_RESET, 8'($urandom), 1'($urandom), 6'($urandom));
            sent++;
         end else if (r < 84) begin
            send(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom), 6'($urandom));
         end else begin
            // new words without a rebuild fail to the root
            r = $urandom_range(1, 3);
            send_keyword(r);
            sent += r;
         end
      end
      drain();
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_INSERT;
      req_symbol = '0;
      req_word_end = 1'b0;
      req_key_select = '0;
      rsp_stall = 1'b0;
      quiet = 0;
      send_idle = 34;
      recv_idle = 50;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_key("he");
      send_key("she");
      send_key("his");
      send_key("hers");
      send_key("he");
      send(KIND_INSERT, 8'h00, 1'b0, 6'd0);
      send(KIND_INSERT, 8'hff, 1'b1, 6'd0);
      send(KIND_BUILD, 8'd0, 1'b0, 6'd0);
      send_text("ush");
      send(KIND_MATCH, CH_CR, 1'b0, 6'd0);
      send(KIND_MATCH, CH_LF, 1'b0, 6'd0);
      send_text("ers");
      send(KIND_MATCH, 8'h00, 1'b0, 6'd0);
      send(KIND_MATCH, 8'hff, 1'b0, 6'd0);
      for (int k = 0; k < 5; k++) send(KIND_READ, 8'd0, 1'b0, 6'(k));
      send(KIND_READ, 8'hff, 1'b1, 6'd63);
      send(3'd5, 8'hff, 1'b1, 6'd63);
      send(3'd7, 8'h00, 1'b0, 6'd0);
      send(KIND_RESET, 8'd0, 1'b0, 6'd0);
      send(KIND_READ, 8'd0, 1'b0, 6'd1);
      send_key("rs");
      send_text("hers");
      drain();

      run_phase(255, 25, 0);
      send_idle = 50;
      recv_idle = 34;
      run_phase(255, 25, 0);
      send_idle = 0;
      recv_idle = 0;
      run_phase(255, 20, 90);

      drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
